/* rtl/oprx_pkg.sv */
// Shared constants, types and helpers for the opaque pixel run extractor.
package oprx_pkg;

	localparam int MaxDim   = 4096;
	localparam int CoordW   = $clog2(MaxDim);
	localparam int SizeW    = CoordW + 1;
	localparam int ColorW   = 24;
	localparam int CfgDataW = 24;
	localparam int CfgIdxW  = 2;

	typedef logic [CoordW-1:0] coord_t;
	typedef logic [SizeW-1:0]  size_t;
	typedef logic [ColorW-1:0] color_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_COLOR    = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} cfg_reg_t;

	// Settings as the scanner uses them: key color and the index of the last column and row.
	typedef struct packed {
		color_t key_color;
		coord_t last_col;
		coord_t last_row;
	} cfg_t;

	typedef struct packed {
		logic   run_valid;
		coord_t run_row;
		coord_t run_left;
		size_t  run_right;
		logic   image_end;
	} run_t;

	// A size of zero counts as one and a size beyond the maximum counts as the maximum.
	function automatic coord_t last_index(size_t v);
		coord_t r;
		if (v == '0) begin
			r = '0;
		end else if (v > size_t'(MaxDim)) begin
			r = coord_t'(MaxDim - 1);
		end else begin
			r = coord_t'(v - size_t'(1));
		end
		return r;
	endfunction

endpackage

/* rtl/oprx_if.sv */
// Handshake interfaces for the pixel word stream and the run word stream.
interface oprx_pix_if;
	import oprx_pkg::*;
	logic   valid;
	logic   ready;
	color_t pixel_color;
	modport source (output valid, output pixel_color, input ready);
	modport sink (input valid, input pixel_color, output ready);
endinterface

interface oprx_run_if;
	import oprx_pkg::*;
	logic   valid;
	logic   ready;
	logic   run_valid;
	coord_t run_row;
	coord_t run_left;
	size_t  run_right;
	logic   image_end;
	modport source (output valid, output run_valid, output run_row, output run_left,
		output run_right, output image_end, input ready);
	modport sink (input valid, input run_valid, input run_row, input run_left,
		input run_right, input image_end, output ready);
endinterface

/* rtl/oprx_cfg.sv */
// Configuration registers and the clamped image size derived from them.
module oprx_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [oprx_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [oprx_pkg::CfgDataW-1:0]     cfg_data,
	output oprx_pkg::cfg_t                    cfg
);
	import oprx_pkg::*;

	color_t key_q;
	size_t  width_q;
	size_t  height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			width_q  <= size_t'(1);
			height_q <= size_t'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_COLOR:    key_q    <= cfg_data[ColorW-1:0];
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[SizeW-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[SizeW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.key_color = key_q;
	assign cfg.last_col  = last_index(width_q);
	assign cfg.last_row  = last_index(height_q);

endmodule

/* rtl/oprx_scan.sv */
// Raster position, run tracking and result formation for one pixel.
module oprx_scan (
	input  logic            clk,
	input  logic            arst_n,
	input  oprx_pkg::cfg_t  cfg,
	input  logic            advance,
	input  oprx_pkg::color_t pixel_color,
	output logic            res_valid,
	output oprx_pkg::run_t  res
);
	import oprx_pkg::*;

	coord_t col_q;
	coord_t row_q;
	logic   inside_q;
	coord_t start_q;

	logic   last_col;
	logic   last_row;
	logic   is_key;
	logic   emit;
	logic   img_end;

	// A position at or past the last index ends the row, so a size change cannot strand it.
	assign last_col = col_q >= cfg.last_col;
	assign last_row = row_q >= cfg.last_row;
	assign is_key   = pixel_color == cfg.key_color;
	assign emit     = is_key ? inside_q : last_col;
	assign img_end  = last_col && last_row;

	assign res_valid = emit || img_end;

	always_comb begin
		res = '0;
		res.image_end = img_end;
		if (emit) begin
			res.run_valid = 1'b1;
			res.run_row   = row_q;
			res.run_left  = inside_q ? start_q : col_q;
			res.run_right = is_key ? {1'b0, col_q} : {1'b0, col_q} + size_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			inside_q <= 1'b0;
			start_q  <= '0;
		end else if (advance) begin
			inside_q <= !last_col && !is_key;
			if (!is_key && !inside_q) begin
				start_q <= col_q;
			end
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + coord_t'(1);
			end else begin
				col_q <= col_q + coord_t'(1);
			end
		end
	end

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res.run_valid |-> ({1'b0, res.run_left} < res.run_right))
		else $error("run word with empty or reversed span");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_col) |=> (col_q == '0 && !inside_q))
		else $error("row end did not reset column and run state");

	a_end_only_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.run_valid) |->
		(res.image_end && res.run_row == '0 && res.run_left == '0 && res.run_right == '0))
		else $error("runless word is not a clean image end word");

endmodule

/* rtl/opaque_pixel_run_extractor.sv */
// Opaque pixel run extractor: takes one pixel word per clock in raster order and emits one run
// word for each horizontal span of pixels that differ from the key color, plus a word flagged
// image_end on the last pixel of each image. A pixel passes an input register, then the scan logic
// and a result register, which holds the run word until the run word stream takes it.
// Throughput is one pixel per clock, limited only by backpressure on the run word stream; the
// result register lets a new pixel enter while a finished word waits. Configuration takes effect
// on the next pixel and should be written between images.
module opaque_pixel_run_extractor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [oprx_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [oprx_pkg::CfgDataW-1:0]  cfg_data,
	oprx_pix_if.sink                       pixel,
	oprx_run_if.source                     runs
);
	import oprx_pkg::*;

	cfg_t   cfg;
	color_t pix_s1;
	logic   valid_s1;
	run_t   res;
	logic   res_valid;
	run_t   out_q;
	logic   out_valid_q;
	logic   out_free;
	logic   advance;

	oprx_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	oprx_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.advance     (advance),
		.pixel_color (pix_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	assign out_free    = !out_valid_q || runs.ready;
	assign advance     = valid_s1 && (!res_valid || out_free);
	assign pixel.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.valid && pixel.ready) begin
			pix_s1 <= pixel.pixel_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign runs.valid     = out_valid_q;
	assign runs.run_valid = out_q.run_valid;
	assign runs.run_row   = out_q.run_row;
	assign runs.run_left  = out_q.run_left;
	assign runs.run_right = out_q.run_right;
	assign runs.image_end = out_q.image_end;

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> (valid_s1 && res_valid && out_valid_q && !runs.ready))
		else $error("pixel stream stalled without a blocked word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !runs.ready) |-> !(advance && res_valid))
		else $error("result register overwritten while its word waits");

endmodule
